### sv/gba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gba_pkg
// Shared constants, status codes, control/status bundles and a helper
// function for the grouped bitmap allocator.
// ----------------------------------------------------------------------------
package gba_pkg;

   // geometry
   localparam int GROUPS          = 8;
   localparam int BITS_PER_GROUP  = 8192;
   localparam int WORD_W          = 64;
   localparam int WORDS_PER_GROUP = BITS_PER_GROUP / WORD_W;
   localparam int TOTAL_WORDS     = GROUPS * WORDS_PER_GROUP;
   localparam int BIT_IDX_W       = $clog2(WORD_W);
   localparam int WORD_IDX_W      = $clog2(WORDS_PER_GROUP);
   localparam int GROUP_IDX_W     = $clog2(GROUPS);
   localparam int ADDR_W          = GROUP_IDX_W + WORD_IDX_W;
   localparam int GRP_SHIFT       = $clog2(BITS_PER_GROUP);

   // field widths
   localparam int ID_W      = 17;
   localparam int STATUS_W  = 2;
   localparam int CFG_W     = 4;
   localparam int GCNT_W    = $clog2(BITS_PER_GROUP + 1);
   localparam int ID_GRP_W  = ID_W - GRP_SHIFT;

   // reset values
   localparam logic [CFG_W-1:0]  GROUPS_IN_USE_RST = CFG_W'(8);
   localparam logic [ID_W-1:0]   TOTAL_RST         = ID_W'(GROUPS * BITS_PER_GROUP);
   localparam logic [GCNT_W-1:0] GCNT_RST          = GCNT_W'(BITS_PER_GROUP);

   // request function codes
   localparam logic FUNC_ALLOC   = 1'b0;
   localparam logic FUNC_RELEASE = 1'b1;

   // response status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_FREE   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_ID    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_ALLOC = 2'd3;

   // controller -> datapath
   typedef struct packed {
      logic                req_take;     // latch request payload
      logic                clr_step;     // clear one bitmap word
      logic                grp_start;    // group pointer to zero
      logic                grp_next;     // advance group pointer
      logic                grp_load_id;  // group pointer from release id
      logic                scan_start;   // word pointer to zero
      logic                scan_issue;   // issue one bitmap read
      logic                word_capture; // hold the non-full word
      logic                alloc_commit; // set bit, count down, post result
      logic                rel_read;     // read the word of the release id
      logic                rel_commit;   // clear bit, count up, post result
      logic                res_load;     // post a failure result
      logic [STATUS_W-1:0] res_status;   // code for res_load
      logic                out_load;     // move result to output register
   } gba_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clr_last;   // last word of the clearing pass
      logic grp_done;   // group pointer past the groups in use
      logic grp_empty;  // current group has no free entry
      logic iss_more;   // words left to issue in this group
      logic rd_vld;     // read data belongs to the scan
      logic word_full;  // read word has no clear bit
      logic chk_last;   // read word is the last of the group
      logic id_bad;     // release id zero or outside groups in use
      logic bit_set;    // release bit is currently allocated
      logic out_busy;   // output register holds an untaken result
   } gba_sts_type;

   // index of the lowest clear bit; binary search, one halving a step
   function automatic logic [BIT_IDX_W-1:0] first_zero(input logic [WORD_W-1:0] word);
      logic [WORD_W-1:0]    cur;
      logic [WORD_W-1:0]    low_mask;
      logic [BIT_IDX_W-1:0] idx;
      cur = word;
      idx = '0;
      for (int s = BIT_IDX_W - 1; s >= 0; s--) begin
         low_mask = (WORD_W'(1) << (1 << s)) - WORD_W'(1);
         if ((cur & low_mask) == low_mask) begin
            cur    = cur >> (1 << s);
            idx[s] = 1'b1;
         end
      end
      return idx;
   endfunction

endpackage

### sv/gba_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gba_ram
// Generic single-port RAM, one read or write per cycle, registered read.
// ----------------------------------------------------------------------------
module gba_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write or registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

### sv/gba_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gba_datapath
// Bitmap RAM, group and total free counters, scan pointers, result staging
// and the output register.
// ----------------------------------------------------------------------------
module gba_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  gba_pkg::gba_cmd_type         cmd,
   output gba_pkg::gba_sts_type         sts,
   input  logic                         req_func,
   input  logic [gba_pkg::ID_W-1:0]     req_item_id,
   input  logic                         csr_we,
   input  logic [gba_pkg::CFG_W-1:0]    csr_wdata,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [gba_pkg::STATUS_W-1:0] rsp_status,
   output logic [gba_pkg::ID_W-1:0]     rsp_granted_id,
   output logic [gba_pkg::ID_W-1:0]     rsp_free_total
);

   localparam int GW = gba_pkg::GROUP_IDX_W;
   localparam int WW = gba_pkg::WORD_IDX_W;
   localparam int BW = gba_pkg::BIT_IDX_W;
   localparam int AW = gba_pkg::ADDR_W;
   localparam int DW = gba_pkg::WORD_W;
   localparam int IW = gba_pkg::ID_W;
   localparam int CW = gba_pkg::CFG_W;
   localparam int NW = gba_pkg::GCNT_W;
   localparam int SW = gba_pkg::STATUS_W;

   // configuration and counters
   logic [CW-1:0] giu_ff;
   logic [NW-1:0] gcnt_ff [gba_pkg::GROUPS];
   logic [IW-1:0] total_ff;
   logic [AW-1:0] clr_ff;

   // request and scan registers
   logic          func_ff;
   logic [IW-1:0] id_ff;
   logic [CW-1:0] g_ff;
   logic [WW:0]   w_iss_ff;
   logic [WW-1:0] w_chk_ff;
   logic          rd_vld_ff;
   logic [DW-1:0] word_ff;
   logic [WW-1:0] wsel_ff;

   // result staging and output register
   logic [SW-1:0] res_status_ff;
   logic [IW-1:0] res_grant_ff;
   logic [IW-1:0] res_total_ff;
   logic          rsp_valid_ff;
   logic [SW-1:0] rsp_status_ff;
   logic [IW-1:0] rsp_grant_ff;
   logic [IW-1:0] rsp_total_ff;

   // combinational
   logic [CW-1:0]       ng;
   logic [GW-1:0]       gsel;
   logic [IW-1:0]       id_n;
   logic [IW-GW-WW-BW-1:0] id_grp_unused;
   logic [gba_pkg::ID_GRP_W-1:0] id_grp;
   logic [WW-1:0]       id_word;
   logic [BW-1:0]       id_bit;
   logic [BW-1:0]       fz_bit;
   logic [AW-1:0]       ram_addr;
   logic                ram_we;
   logic [DW-1:0]       ram_wdata;
   logic [DW-1:0]       ram_rdata;

   // active group count, clamped to the groups built
   assign ng   = (giu_ff > CW'(gba_pkg::GROUPS)) ? CW'(gba_pkg::GROUPS) : giu_ff;
   assign gsel = g_ff[GW-1:0];

   // split of a one-based release id into group, word and bit
   assign id_n          = id_ff - IW'(1);
   assign id_grp        = id_n[IW-1:gba_pkg::GRP_SHIFT];
   assign id_grp_unused = id_n[IW-1:GW+WW+BW];
   assign id_word       = id_n[gba_pkg::GRP_SHIFT-1:BW];
   assign id_bit        = id_n[BW-1:0];

   assign fz_bit = gba_pkg::first_zero(word_ff);

   // bitmap RAM port selection
   always_comb begin
      ram_we    = 1'b0;
      ram_addr  = {gsel, id_word};
      ram_wdata = '0;
      if (cmd.clr_step) begin
         ram_we   = 1'b1;
         ram_addr = clr_ff;
      end else if (cmd.scan_issue) begin
         ram_addr = {gsel, w_iss_ff[WW-1:0]};
      end else if (cmd.alloc_commit) begin
         ram_we    = 1'b1;
         ram_addr  = {gsel, wsel_ff};
         ram_wdata = word_ff | (DW'(1) << fz_bit);
      end else if (cmd.rel_read) begin
         ram_addr = {gsel, id_word};
      end else if (cmd.rel_commit) begin
         ram_we    = 1'b1;
         ram_wdata = ram_rdata & ~(DW'(1) << id_bit);
      end
   end

   gba_ram #(
      .WIDTH (DW),
      .DEPTH (gba_pkg::TOTAL_WORDS)
   ) u_bitmap (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // control registers: config, counters, clear pointer, output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         giu_ff       <= gba_pkg::GROUPS_IN_USE_RST;
         total_ff     <= gba_pkg::TOTAL_RST;
         clr_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < gba_pkg::GROUPS; i++) begin
            gcnt_ff[i] <= gba_pkg::GCNT_RST;
         end
      end else begin
         if (csr_we) begin
            giu_ff <= csr_wdata;
         end
         if (cmd.clr_step) begin
            clr_ff <= clr_ff + AW'(1);
         end
         rd_vld_ff <= cmd.scan_issue;
         if (cmd.alloc_commit) begin
            gcnt_ff[gsel] <= gcnt_ff[gsel] - NW'(1);
            total_ff      <= total_ff - IW'(1);
         end else if (cmd.rel_commit) begin
            gcnt_ff[gsel] <= gcnt_ff[gsel] + NW'(1);
            total_ff      <= total_ff + IW'(1);
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.req_take) begin
         func_ff <= req_func;
         id_ff   <= req_item_id;
      end
      if (cmd.grp_start) begin
         g_ff <= '0;
      end else if (cmd.grp_next) begin
         g_ff <= g_ff + CW'(1);
      end else if (cmd.grp_load_id) begin
         g_ff <= CW'(id_grp);
      end
      if (cmd.scan_start) begin
         w_iss_ff <= '0;
      end else if (cmd.scan_issue) begin
         w_iss_ff <= w_iss_ff + (WW+1)'(1);
      end
      if (cmd.scan_issue) begin
         w_chk_ff <= w_iss_ff[WW-1:0];
      end
      if (cmd.word_capture) begin
         word_ff <= ram_rdata;
         wsel_ff <= w_chk_ff;
      end
      // result staging
      if (cmd.alloc_commit) begin
         res_status_ff <= gba_pkg::ST_OK;
         res_grant_ff  <= IW'({gsel, wsel_ff, fz_bit}) + IW'(1);
         res_total_ff  <= total_ff - IW'(1);
      end else if (cmd.rel_commit) begin
         res_status_ff <= gba_pkg::ST_OK;
         res_grant_ff  <= '0;
         res_total_ff  <= total_ff + IW'(1);
      end else if (cmd.res_load) begin
         res_status_ff <= cmd.res_status;
         res_grant_ff  <= '0;
         res_total_ff  <= total_ff;
      end
      if (cmd.out_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_grant_ff  <= res_grant_ff;
         rsp_total_ff  <= res_total_ff;
      end
   end

   // status to controller
   always_comb begin
      sts.clr_last  = (clr_ff == AW'(gba_pkg::TOTAL_WORDS - 1));
      sts.grp_done  = (g_ff >= ng);
      sts.grp_empty = (gcnt_ff[gsel] == '0);
      sts.iss_more  = !w_iss_ff[WW];
      sts.rd_vld    = rd_vld_ff;
      sts.word_full = &ram_rdata;
      sts.chk_last  = &w_chk_ff;
      sts.id_bad    = (id_ff == '0) || (id_grp >= ng) || (func_ff != gba_pkg::FUNC_RELEASE)
                      || ((|id_grp_unused) && (id_grp < ng));
      sts.bit_set   = ram_rdata[id_bit];
      sts.out_busy  = rsp_valid_ff;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_granted_id = rsp_grant_ff;
   assign rsp_free_total = rsp_total_ff;

   // a pending result is never overwritten
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("output register overwritten while holding a result");

   // allocation only from a group with free entries
   a_alloc_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.alloc_commit |-> (gcnt_ff[gsel] != '0) && (total_ff != '0))
      else $error("allocation from an empty group");

   // allocation lowers the total by one
   a_alloc_total: assert property (@(posedge clock) disable iff (reset)
      cmd.alloc_commit |=> (total_ff == $past(total_ff) - IW'(1)))
      else $error("total free count not lowered on allocation");

   // a captured word always has a clear bit
   a_capture_free: assert property (@(posedge clock) disable iff (reset)
      cmd.word_capture |-> rd_vld_ff && !(&ram_rdata))
      else $error("full word captured for allocation");

   // release commits only on an allocated bit
   a_release_set: assert property (@(posedge clock) disable iff (reset)
      cmd.rel_commit |-> ram_rdata[id_bit] && (total_ff < gba_pkg::TOTAL_RST))
      else $error("release of a free entry committed");

endmodule

### sv/gba_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gba_ctrl
// Sequencer for the allocator: clearing pass, group walk, word scan,
// release read-modify-write and result hand-off.
// ----------------------------------------------------------------------------
module gba_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_func,
   output logic                 req_ready,
   input  logic                 rsp_ready,
   input  gba_pkg::gba_sts_type sts,
   output gba_pkg::gba_cmd_type cmd
);

   localparam logic [3:0] S_CLEAR   = 4'd0;
   localparam logic [3:0] S_IDLE    = 4'd1;
   localparam logic [3:0] S_GRP     = 4'd2;
   localparam logic [3:0] S_SCAN    = 4'd3;
   localparam logic [3:0] S_FOUND   = 4'd4;
   localparam logic [3:0] S_REL_CHK = 4'd5;
   localparam logic [3:0] S_REL_RD  = 4'd6;
   localparam logic [3:0] S_REL_WR  = 4'd7;
   localparam logic [3:0] S_RESP    = 4'd8;

   logic [3:0] state_ff;
   logic [3:0] state_in;
   logic       hit;

   // scan found a word with a clear bit
   assign hit = sts.rd_vld && !sts.word_full;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.req_take  = 1'b1;
               cmd.grp_start = 1'b1;
               state_in = (req_func == gba_pkg::FUNC_ALLOC) ? S_GRP : S_REL_CHK;
            end
         end
         S_GRP: begin
            if (sts.grp_done) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = gba_pkg::ST_NO_FREE;
               state_in       = S_RESP;
            end else if (sts.grp_empty) begin
               cmd.grp_next = 1'b1;
            end else begin
               cmd.scan_start = 1'b1;
               state_in       = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan_issue = sts.iss_more && !hit;
            if (hit) begin
               cmd.word_capture = 1'b1;
               state_in         = S_FOUND;
            end else if (sts.rd_vld && sts.chk_last) begin
               cmd.grp_next = 1'b1;
               state_in     = S_GRP;
            end
         end
         S_FOUND: begin
            cmd.alloc_commit = 1'b1;
            state_in         = S_RESP;
         end
         S_REL_CHK: begin
            cmd.grp_load_id = 1'b1;
            if (sts.id_bad) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = gba_pkg::ST_BAD_ID;
               state_in       = S_RESP;
            end else begin
               state_in = S_REL_RD;
            end
         end
         S_REL_RD: begin
            cmd.rel_read = 1'b1;
            state_in     = S_REL_WR;
         end
         S_REL_WR: begin
            if (sts.bit_set) begin
               cmd.rel_commit = 1'b1;
            end else begin
               cmd.res_load   = 1'b1;
               cmd.res_status = gba_pkg::ST_NOT_ALLOC;
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!sts.out_busy || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // no request taken during the clearing pass
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !req_ready && !cmd.alloc_commit && !cmd.rel_commit)
      else $error("request activity during clearing pass");

   // every taken request ends in exactly one result hand-off before the next
   a_resp_to_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> (state_ff == S_IDLE))
      else $error("result hand-off did not return to idle");

   // a commit always precedes a result hand-off
   a_commit_resp: assert property (@(posedge clock) disable iff (reset)
      (cmd.alloc_commit || cmd.rel_commit || cmd.res_load) |=> (state_ff == S_RESP))
      else $error("result staged without hand-off");

endmodule

### sv/grouped_bitmap_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grouped_bitmap_allocator
// First-fit allocator over a bitmap split into groups with per-group and
// total free counts. Allocate returns the lowest free one-based id;
// release frees a given id.
// ----------------------------------------------------------------------------
//  channel  direction  transfer when            payload
//  req_     in         req_valid & req_ready    req_func, req_item_id
//  rsp_     out        rsp_valid & rsp_ready    rsp_status, rsp_granted_id,
//                                               rsp_free_total
//  csr_     in         csr_we                   csr_wdata (groups in use)
//
//  Release: request transfer to rsp_valid passes through id check, RAM
//  read, bit check and write, and output load.
//  Allocate: empty groups are skipped and each group scanned is read word
//  by word; the word scan reads one 64-bit bitmap word per cycle from the
//  single-port RAM.
//  req_ready returns in the cycle after the result is loaded.
//  Reset: a clearing pass zeroes all 1024 bitmap words, req_ready low.
//  A finished result waits in the output register; the next request is
//  accepted meanwhile and its result is held until rsp_ready frees it.
// ----------------------------------------------------------------------------
module grouped_bitmap_allocator (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_func,
   input  logic [gba_pkg::ID_W-1:0]     req_item_id,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [gba_pkg::STATUS_W-1:0] rsp_status,
   output logic [gba_pkg::ID_W-1:0]     rsp_granted_id,
   output logic [gba_pkg::ID_W-1:0]     rsp_free_total,
   input  logic                         csr_we,
   input  logic [gba_pkg::CFG_W-1:0]    csr_wdata
);

   gba_pkg::gba_cmd_type cmd;
   gba_pkg::gba_sts_type sts;

   // sequencer
   gba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_ready (req_ready),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // bitmap, counters and result path
   gba_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_func       (req_func),
      .req_item_id    (req_item_id),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_granted_id (rsp_granted_id),
      .rsp_free_total (rsp_free_total)
   );

endmodule

### bench/tb_grouped_bitmap_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grouped_bitmap_allocator
// Self-checking bench for the grouped bitmap allocator. A scoreboard class
// keeps its own copy of the bitmap, group counts and total, predicts every
// response at request transfer and checks responses in order. Stimulus is a
// short directed pass over the group settings and id edges, then random
// allocate/release traffic under several group settings and idle patterns.
// ----------------------------------------------------------------------------
module tb_grouped_bitmap_allocator;

   localparam int unsigned CYCLE_LIMIT  = 8_000_000;
   localparam int unsigned PHASE_ITEMS  = 362;
   localparam int unsigned TAIL_CYCLES  = 200;

   // one predicted response
   typedef struct packed {
      logic [gba_pkg::STATUS_W-1:0] status;
      logic [gba_pkg::ID_W-1:0]     granted_id;
      logic [gba_pkg::ID_W-1:0]     free_total;
   } gba_answer_type;

   // ------------------------------------------------------------------------
   // allocation book: shadow bitmap and counts, queue of pending answers
   // ------------------------------------------------------------------------
   class alloc_book;
      logic [gba_pkg::WORD_W-1:0] used_words [gba_pkg::TOTAL_WORDS];
      int unsigned                group_free [gba_pkg::GROUPS];
      int unsigned                free_count;
      logic [gba_pkg::CFG_W-1:0]  groups_cfg;
      gba_answer_type             answer_q [$];
      int unsigned                status_tally [4];
      int unsigned                mismatches;
      int unsigned                checked;

      function new();
         foreach (used_words[w]) used_words[w] = '0;
         foreach (group_free[g]) group_free[g] = gba_pkg::BITS_PER_GROUP;
         foreach (status_tally[s]) status_tally[s] = 0;
         free_count = gba_pkg::GROUPS * gba_pkg::BITS_PER_GROUP;
         groups_cfg = gba_pkg::GROUPS_IN_USE_RST;
         mismatches = 0;
         checked    = 0;
      endfunction

      function void set_groups(logic [gba_pkg::CFG_W-1:0] value);
         groups_cfg = value;
      endfunction

      function int unsigned pending();
         return answer_q.size();
      endfunction

      // predict the response of one accepted request and queue it
      function gba_answer_type take_request(logic func, logic [gba_pkg::ID_W-1:0] id);
         gba_answer_type ans;
         int unsigned ng;
         int unsigned grp;
         int unsigned wd;
         int unsigned bt;
         int unsigned widx;
         int unsigned entry;
         bit          found;
         ng  = (groups_cfg > gba_pkg::GROUPS) ? gba_pkg::GROUPS : groups_cfg;
         ans.status     = gba_pkg::ST_OK;
         ans.granted_id = '0;
         found = 1'b0;
         if (func == gba_pkg::FUNC_ALLOC) begin
            // first fit: skip empty groups, lowest clear bit wins
            ans.status = gba_pkg::ST_NO_FREE;
            for (grp = 0; grp < ng && !found; grp++) begin
               if (group_free[grp] == 0) continue;
               for (wd = 0; wd < gba_pkg::WORDS_PER_GROUP && !found; wd++) begin
                  widx = grp * gba_pkg::WORDS_PER_GROUP + wd;
                  if (&used_words[widx]) continue;
                  for (bt = 0; bt < gba_pkg::WORD_W; bt++)
                     if (!used_words[widx][bt]) break;
                  used_words[widx][bt] = 1'b1;
                  group_free[grp]--;
                  free_count--;
                  found          = 1'b1;
                  ans.status     = gba_pkg::ST_OK;
                  ans.granted_id = gba_pkg::ID_W'(grp * gba_pkg::BITS_PER_GROUP
                                                  + wd * gba_pkg::WORD_W + bt + 1);
               end
            end
         end else begin
            if (id == '0) begin
               ans.status = gba_pkg::ST_BAD_ID;
            end else begin
               entry = id - 1;
               grp   = entry / gba_pkg::BITS_PER_GROUP;
               widx  = entry / gba_pkg::WORD_W;
               bt    = entry % gba_pkg::WORD_W;
               if (grp >= ng) begin
                  ans.status = gba_pkg::ST_BAD_ID;
               end else if (!used_words[widx][bt]) begin
                  ans.status = gba_pkg::ST_NOT_ALLOC;
               end else begin
                  used_words[widx][bt] = 1'b0;
                  group_free[grp]++;
                  free_count++;
               end
            end
         end
         ans.free_total = gba_pkg::ID_W'(free_count);
         answer_q.push_back(ans);
         status_tally[ans.status]++;
         return ans;
      endfunction

      // compare one response transfer with the oldest prediction
      function void check_response(logic [gba_pkg::STATUS_W-1:0] status,
                                   logic [gba_pkg::ID_W-1:0] granted,
                                   logic [gba_pkg::ID_W-1:0] total);
         gba_answer_type want;
         checked++;
         if (answer_q.size() == 0) begin
            $error("response with nothing outstanding: status %0d, granted_id %0d",
                   status, granted);
            mismatches++;
            return;
         end
         want = answer_q.pop_front();
         if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            mismatches++;
         end
         if (granted !== want.granted_id) begin
            $error("granted_id: expected %0d, got %0d", want.granted_id, granted);
            mismatches++;
         end
         if (total !== want.free_total) begin
            $error("free_total: expected %0d, got %0d", want.free_total, total);
            mismatches++;
         end
      endfunction
   endclass

   // ------------------------------------------------------------------------
   // signals
   // ------------------------------------------------------------------------
   logic                         clock          = 1'b0;
   logic                         reset          = 1'b1;
   logic                         req_valid      = 1'b0;
   logic                         req_ready;
   logic                         req_func       = gba_pkg::FUNC_ALLOC;
   logic [gba_pkg::ID_W-1:0]     req_item_id    = '0;
   logic                         rsp_valid;
   logic                         rsp_ready      = 1'b0;
   logic [gba_pkg::STATUS_W-1:0] rsp_status;
   logic [gba_pkg::ID_W-1:0]     rsp_granted_id;
   logic [gba_pkg::ID_W-1:0]     rsp_free_total;
   logic                         csr_we         = 1'b0;
   logic [gba_pkg::CFG_W-1:0]    csr_wdata      = '0;

   alloc_book   book;
   int unsigned sender_idle_pct = 0;
   int unsigned recv_stall_pct  = 0;
   int unsigned cycle_count     = 0;
   int unsigned n_settings      = 0;
   int unsigned live_ids [$];
   int unsigned last_freed      = 1;

   grouped_bitmap_allocator u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_item_id    (req_item_id),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_granted_id (rsp_granted_id),
      .rsp_free_total (rsp_free_total),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata)
   );

   always #10 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("** grouped_bitmap_allocator: FAILED **");
         $finish;
      end
   end

   // response side: check on transfer, random back-pressure
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         book.check_response(rsp_status, rsp_granted_id, rsp_free_total);
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // ------------------------------------------------------------------------
   // drivers
   // ------------------------------------------------------------------------
   // one request transfer, with an optional random gap ahead of it
   task automatic send_request(input logic func, input logic [gba_pkg::ID_W-1:0] id,
                               output gba_answer_type answer);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_valid   <= 1'b1;
      req_func    <= func;
      req_item_id <= id;
      do @(posedge clock); while (!req_ready);
      answer = book.take_request(func, id);
   endtask

   // stop sending and wait until every predicted response has arrived
   task automatic wait_for_quiet();
      req_valid <= 1'b0;
      while (book.pending() != 0) @(posedge clock);
   endtask

   task automatic write_groups(input logic [gba_pkg::CFG_W-1:0] value);
      wait_for_quiet();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      book.set_groups(value);
      n_settings++;
   endtask

   // one random request: mostly allocate / release of live ids, some noise
   task automatic random_request();
      gba_answer_type answer;
      int unsigned roll;
      int unsigned pick;
      int unsigned rid;
      roll = $urandom_range(99);
      if (roll < 48 || live_ids.size() == 0) begin
         send_request(gba_pkg::FUNC_ALLOC, gba_pkg::ID_W'($urandom), answer);
         if (answer.status == gba_pkg::ST_OK) live_ids.push_back(answer.granted_id);
      end else if (roll < 80) begin
         pick = $urandom_range(live_ids.size() - 1);
         rid  = live_ids[pick];
         send_request(gba_pkg::FUNC_RELEASE, gba_pkg::ID_W'(rid), answer);
         if (answer.status == gba_pkg::ST_OK) begin
            live_ids.delete(pick);
            last_freed = rid;
         end
      end else if (roll < 88) begin
         send_request(gba_pkg::FUNC_RELEASE, gba_pkg::ID_W'($urandom), answer);
      end else if (roll < 94) begin
         // release again what was just freed
         send_request(gba_pkg::FUNC_RELEASE, gba_pkg::ID_W'(last_freed), answer);
      end else begin
         // group edges: last entry of one group, first of the next
         rid = $urandom_range(gba_pkg::GROUPS) * gba_pkg::BITS_PER_GROUP
               + $urandom_range(1);
         send_request(gba_pkg::FUNC_RELEASE, gba_pkg::ID_W'(rid), answer);
      end
   endtask

   task automatic run_phase(input int unsigned send_pct, input int unsigned stall_pct,
                            input logic [gba_pkg::CFG_W-1:0] groups);
      write_groups(groups);
      sender_idle_pct = send_pct;
      recv_stall_pct  = stall_pct;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
         // hold off mid-phase until the pipe is empty
         if (i == PHASE_ITEMS / 2) wait_for_quiet();
         random_request();
      end
   endtask

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   initial begin
      gba_answer_type answer;
      book = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: basic grant/release, double release, bad ids, id field extremes
      send_request(gba_pkg::FUNC_ALLOC,   '0,                   answer);
      send_request(gba_pkg::FUNC_ALLOC,   '0,                   answer);
      send_request(gba_pkg::FUNC_RELEASE, gba_pkg::ID_W'(2),     answer);
      send_request(gba_pkg::FUNC_RELEASE, gba_pkg::ID_W'(2),     answer);
      send_request(gba_pkg::FUNC_RELEASE, '0,                   answer);
      send_request(gba_pkg::FUNC_RELEASE, gba_pkg::ID_W'(65536), answer);
      send_request(gba_pkg::FUNC_RELEASE, gba_pkg::ID_W'(65537), answer);
      send_request(gba_pkg::FUNC_RELEASE, '1,                   answer);
      send_request(gba_pkg::FUNC_ALLOC,   '1,                   answer);
      send_request(gba_pkg::FUNC_RELEASE, gba_pkg::ID_W'(1),     answer);
      send_request(gba_pkg::FUNC_ALLOC,   '0,                   answer);

      // no groups in use: nothing free, every release out of range
      write_groups(4'd0);
      send_request(gba_pkg::FUNC_ALLOC,   '0,                   answer);
      send_request(gba_pkg::FUNC_RELEASE, gba_pkg::ID_W'(1),     answer);

      // setting above the group count behaves as all groups
      write_groups(4'd15);
      send_request(gba_pkg::FUNC_RELEASE, gba_pkg::ID_W'(65536), answer);
      send_request(gba_pkg::FUNC_ALLOC,   '0,                   answer);

      // single group: next group out of range, last entry of group 0 free
      write_groups(4'd1);
      send_request(gba_pkg::FUNC_RELEASE, gba_pkg::ID_W'(8193),  answer);
      send_request(gba_pkg::FUNC_RELEASE, gba_pkg::ID_W'(8192),  answer);

      // random traffic under different settings and idle patterns
      run_phase(0,  0,  4'd8);
      run_phase(83, 0,  4'd3);
      run_phase(0,  83, 4'd15);
      run_phase(23, 23, 4'd2);

      wait_for_quiet();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Run: %0d responses checked over %0d group settings, incl. zero groups.",
               book.checked, n_settings + 1);
      $display("Answers: %0d ok, %0d nothing free, %0d id out of range, %0d not allocated.",
               book.status_tally[gba_pkg::ST_OK], book.status_tally[gba_pkg::ST_NO_FREE],
               book.status_tally[gba_pkg::ST_BAD_ID],
               book.status_tally[gba_pkg::ST_NOT_ALLOC]);
      if (book.mismatches == 0 && book.pending() == 0) begin
         $display("** grouped_bitmap_allocator: PASSED **");
      end else begin
         $display("** grouped_bitmap_allocator: FAILED **");
      end
      $finish;
   end

endmodule

### files.f
sv/gba_pkg.sv
sv/gba_ram.sv
sv/gba_datapath.sv
sv/gba_ctrl.sv
sv/grouped_bitmap_allocator.sv
bench/tb_grouped_bitmap_allocator.sv
